### rtl/selc_pkg.sv
// Shared types, constants and widths for the sparse empty line compactor.
// Depends on nothing; selc_maps, selc_seq and the top level refer to it by scoped names.
package selc_pkg;

   // Largest matrix dimensions that the line maps can hold.
   localparam int MAX_ROWS  = 4096;
   localparam int MAX_COLS  = 4096;
   localparam int MAX_LINES = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

   // Address widths of the row and column memories.
   localparam int ROW_AW = $clog2(MAX_ROWS);
   localparam int COL_AW = $clog2(MAX_COLS);

   // Walk counter width: holds a line index and the line count itself.
   localparam int IDX_W = $clog2(MAX_LINES) + 1;

   // Field widths of the request and response channels.
   localparam int ENTRY_W = 12;
   localparam int DIM_W   = 13;

   // A memory word is the used flag over the inclusive empty-line count.
   localparam int WORD_W = DIM_W + 1;

   // Configuration port.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 2'd1;
   localparam logic [DIM_W-1:0]     DIM_RESET    = 13'd4096;

   // Request actions.
   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_MARK  = 2'd1,
      ACT_BUILD = 2'd2,
      ACT_REMAP = 2'd3
   } action_type;

   // One cycle of access to the row memory.
   typedef struct packed {
      logic              rd_en;
      logic [ROW_AW-1:0] rd_addr;
      logic              wr_en;
      logic [ROW_AW-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
   } row_req_type;

   // One cycle of access to the column memory.
   typedef struct packed {
      logic              rd_en;
      logic [COL_AW-1:0] rd_addr;
      logic              wr_en;
      logic [COL_AW-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
   } col_req_type;

   // Status of the walk sequencer toward the top level.
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIM_W-1:0] empty_rows;
      logic [DIM_W-1:0] empty_cols;
   } seq_stat_type;

endpackage

### rtl/selc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; a read in the same cycle as a write to that entry returns the old word.
module selc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and read register.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/selc_maps.sv
// Row and column line memories with a bypass of the most recent write.
// Depends on selc_pkg and selc_ram.
module selc_maps (
   input  logic                         clock,
   input  logic                         reset,
   input  selc_pkg::row_req_type        row_req,
   input  selc_pkg::col_req_type        col_req,
   output logic [selc_pkg::WORD_W-1:0]  row_rd,
   output logic [selc_pkg::WORD_W-1:0]  col_rd
);

   logic [selc_pkg::WORD_W-1:0] row_q;
   logic [selc_pkg::WORD_W-1:0] col_q;

   logic                        row_fwd_valid_ff;
   logic [selc_pkg::ROW_AW-1:0] row_fwd_addr_ff;
   logic [selc_pkg::WORD_W-1:0] row_fwd_data_ff;
   logic [selc_pkg::ROW_AW-1:0] row_rd_addr_ff;

   logic                        col_fwd_valid_ff;
   logic [selc_pkg::COL_AW-1:0] col_fwd_addr_ff;
   logic [selc_pkg::WORD_W-1:0] col_fwd_data_ff;
   logic [selc_pkg::COL_AW-1:0] col_rd_addr_ff;

   selc_ram #(
      .WIDTH (selc_pkg::WORD_W),
      .DEPTH (selc_pkg::MAX_ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_req.wr_en),
      .wr_addr (row_req.wr_addr),
      .wr_data (row_req.wr_data),
      .rd_en   (row_req.rd_en),
      .rd_addr (row_req.rd_addr),
      .rd_data (row_q)
   );

   selc_ram #(
      .WIDTH (selc_pkg::WORD_W),
      .DEPTH (selc_pkg::MAX_COLS)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (col_req.wr_en),
      .wr_addr (col_req.wr_addr),
      .wr_data (col_req.wr_data),
      .rd_en   (col_req.rd_en),
      .rd_addr (col_req.rd_addr),
      .rd_data (col_q)
   );

   // The bypass always holds the latest write, so a match is always the current word.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_fwd_valid_ff <= 1'b0;
         col_fwd_valid_ff <= 1'b0;
      end else begin
         if (row_req.wr_en) begin
            row_fwd_valid_ff <= 1'b1;
         end
         if (col_req.wr_en) begin
            col_fwd_valid_ff <= 1'b1;
         end
      end
   end

   // Bypass payload and the address of the word now on the read register.
   always_ff @(posedge clock) begin
      if (row_req.wr_en) begin
         row_fwd_addr_ff <= row_req.wr_addr;
         row_fwd_data_ff <= row_req.wr_data;
      end
      if (col_req.wr_en) begin
         col_fwd_addr_ff <= col_req.wr_addr;
         col_fwd_data_ff <= col_req.wr_data;
      end
      if (row_req.rd_en) begin
         row_rd_addr_ff <= row_req.rd_addr;
      end
      if (col_req.rd_en) begin
         col_rd_addr_ff <= col_req.rd_addr;
      end
   end

   // Replace a read that raced a write to the same entry.
   assign row_rd = (row_fwd_valid_ff && (row_fwd_addr_ff == row_rd_addr_ff)) ?
                   row_fwd_data_ff : row_q;
   assign col_rd = (col_fwd_valid_ff && (col_fwd_addr_ff == col_rd_addr_ff)) ?
                   col_fwd_data_ff : col_q;

endmodule

### rtl/selc_seq.sv
// Walk sequencer: sweeps the line memories for the clear pass and the count build.
// Depends on selc_pkg; its reads and writes go to selc_maps through the top level.
module selc_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start_clear,
   input  logic                         start_build,
   input  logic [selc_pkg::DIM_W-1:0]   dim_rows,
   input  logic [selc_pkg::DIM_W-1:0]   dim_cols,
   input  logic [selc_pkg::WORD_W-1:0]  row_rd,
   input  logic [selc_pkg::WORD_W-1:0]  col_rd,
   output selc_pkg::row_req_type        row_req,
   output selc_pkg::col_req_type        col_req,
   output selc_pkg::seq_stat_type       stat
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CLEAR,
      S_BUILD,
      S_FINISH
   } state_type;

   state_type                   state_ff,   state_in;
   logic [selc_pkg::IDX_W-1:0]  idx_ff,     idx_in;
   logic [selc_pkg::IDX_W-1:0]  len_ff,     len_in;
   logic [selc_pkg::IDX_W-1:0]  row_lim_ff, row_lim_in;
   logic [selc_pkg::IDX_W-1:0]  col_lim_ff, col_lim_in;
   logic                        zero_ff,    zero_in;
   logic                        wb_valid_ff, wb_valid_in;
   logic [selc_pkg::IDX_W-1:0]  wb_addr_ff, wb_addr_in;
   logic [selc_pkg::DIM_W-1:0]  acc_row_ff, acc_row_in;
   logic [selc_pkg::DIM_W-1:0]  acc_col_ff, acc_col_in;

   logic                        walking;
   logic                        building;
   logic                        done;
   logic [selc_pkg::DIM_W-1:0]  row_step;
   logic [selc_pkg::DIM_W-1:0]  col_step;
   logic [selc_pkg::DIM_W-1:0]  dim_max;

   assign walking  = (state_ff == S_CLEAR) || (state_ff == S_BUILD);
   assign building = (state_ff == S_BUILD);
   assign dim_max  = (dim_rows > dim_cols) ? dim_rows : dim_cols;

   // Running empty counts include the line being written back.
   assign row_step = acc_row_ff + {{(selc_pkg::DIM_W-1){1'b0}}, ~row_rd[selc_pkg::WORD_W-1]};
   assign col_step = acc_col_ff + {{(selc_pkg::DIM_W-1){1'b0}}, ~col_rd[selc_pkg::WORD_W-1]};

   // Next state, read issue and write-back of the walk.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      row_lim_in  = row_lim_ff;
      col_lim_in  = col_lim_ff;
      zero_in     = zero_ff;
      wb_valid_in = 1'b0;
      wb_addr_in  = wb_addr_ff;
      acc_row_in  = acc_row_ff;
      acc_col_in  = acc_col_ff;
      row_req     = '0;
      col_req     = '0;
      done        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start_clear) begin
               state_in   = S_CLEAR;
               idx_in     = '0;
               len_in     = selc_pkg::IDX_W'(selc_pkg::MAX_LINES);
               row_lim_in = selc_pkg::IDX_W'(selc_pkg::MAX_ROWS);
               col_lim_in = selc_pkg::IDX_W'(selc_pkg::MAX_COLS);
               zero_in    = 1'b0;
            end else if (start_build) begin
               state_in   = S_BUILD;
               idx_in     = '0;
               len_in     = selc_pkg::IDX_W'(dim_max);
               row_lim_in = selc_pkg::IDX_W'(dim_rows);
               col_lim_in = selc_pkg::IDX_W'(dim_cols);
               zero_in    = 1'b0;
               acc_row_in = '0;
               acc_col_in = '0;
            end
         end
         S_CLEAR, S_BUILD: begin
            // Leave once every read is issued and the last write-back is done.
            if ((idx_ff == len_ff) && !wb_valid_ff) begin
               state_in = building ? S_FINISH : S_IDLE;
            end
         end
         S_FINISH: begin
            done     = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Issue one read of each memory per cycle.
      if (walking && (idx_ff != len_ff)) begin
         row_req.rd_en   = 1'b1;
         row_req.rd_addr = selc_pkg::ROW_AW'(idx_ff);
         col_req.rd_en   = 1'b1;
         col_req.rd_addr = selc_pkg::COL_AW'(idx_ff);
         wb_valid_in     = 1'b1;
         wb_addr_in      = idx_ff;
         idx_in          = idx_ff + 1'b1;
      end

      // Write back the word read in the previous cycle.
      if (walking && wb_valid_ff && (wb_addr_ff < row_lim_ff)) begin
         row_req.wr_en   = 1'b1;
         row_req.wr_addr = selc_pkg::ROW_AW'(wb_addr_ff);
         if (building) begin
            row_req.wr_data = {row_rd[selc_pkg::WORD_W-1], row_step};
            acc_row_in      = row_step;
         end else begin
            row_req.wr_data = {1'b0, zero_ff ? {selc_pkg::DIM_W{1'b0}} :
                                               row_rd[selc_pkg::DIM_W-1:0]};
         end
      end
      if (walking && wb_valid_ff && (wb_addr_ff < col_lim_ff)) begin
         col_req.wr_en   = 1'b1;
         col_req.wr_addr = selc_pkg::COL_AW'(wb_addr_ff);
         if (building) begin
            col_req.wr_data = {col_rd[selc_pkg::WORD_W-1], col_step};
            acc_col_in      = col_step;
         end else begin
            col_req.wr_data = {1'b0, zero_ff ? {selc_pkg::DIM_W{1'b0}} :
                                               col_rd[selc_pkg::DIM_W-1:0]};
         end
      end
   end

   // State and walk registers; reset starts a clearing pass that zeroes every word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         idx_ff      <= '0;
         len_ff      <= selc_pkg::IDX_W'(selc_pkg::MAX_LINES);
         row_lim_ff  <= selc_pkg::IDX_W'(selc_pkg::MAX_ROWS);
         col_lim_ff  <= selc_pkg::IDX_W'(selc_pkg::MAX_COLS);
         zero_ff     <= 1'b1;
         wb_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         len_ff      <= len_in;
         row_lim_ff  <= row_lim_in;
         col_lim_ff  <= col_lim_in;
         zero_ff     <= zero_in;
         wb_valid_ff <= wb_valid_in;
      end
   end

   // Write-back address and running counts.
   always_ff @(posedge clock) begin
      wb_addr_ff <= wb_addr_in;
      acc_row_ff <= acc_row_in;
      acc_col_ff <= acc_col_in;
   end

   assign stat.busy       = (state_ff != S_IDLE);
   assign stat.done       = done;
   assign stat.empty_rows = acc_row_ff;
   assign stat.empty_cols = acc_col_ff;

endmodule

### rtl/sparse_empty_line_compactor.sv
// Top level of the sparse empty line compactor: request stage, result register, CSRs.
// Depends on selc_pkg, selc_maps and selc_seq.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  action, entry_row, entry_col
//   rsp_      out        rsp_valid/rsp_stall  new_row, new_col, new_num_rows,
//                                             new_num_cols, has_empty, out_of_range
//   csr_      in         csr_valid/csr_ready  index, data (always ready)
//
// Mark and remap requests stream at one per cycle while no result stalls; each result is
// registered first in the read stage, beside the memory read, then in the result register.
// A clear walks both line memories over MAX_LINES lines; a build walks max(rows, cols)
// lines before its result. Neither takes requests while walking.
// After reset a clearing pass over every line runs before the first request is taken.
// A stalled result holds; one more request may sit in the read stage behind it.
module sparse_empty_line_compactor (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [selc_pkg::ENTRY_W-1:0]    req_entry_row,
   input  logic [selc_pkg::ENTRY_W-1:0]    req_entry_col,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [selc_pkg::ENTRY_W-1:0]    rsp_new_row,
   output logic [selc_pkg::ENTRY_W-1:0]    rsp_new_col,
   output logic [selc_pkg::DIM_W-1:0]      rsp_new_num_rows,
   output logic [selc_pkg::DIM_W-1:0]      rsp_new_num_cols,
   output logic                            rsp_has_empty,
   output logic                            rsp_out_of_range,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [selc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [selc_pkg::DIM_W-1:0]      csr_data
);

   logic [selc_pkg::DIM_W-1:0]   num_rows_ff;
   logic [selc_pkg::DIM_W-1:0]   num_cols_ff;
   logic [selc_pkg::DIM_W-1:0]   dim_rows;
   logic [selc_pkg::DIM_W-1:0]   dim_cols;

   selc_pkg::action_type         req_act;
   logic                         req_fire;
   logic                         req_oor;

   logic                         s1_valid_ff, s1_valid_in;
   selc_pkg::action_type         s1_action_ff;
   logic                         s1_oor_ff;
   logic [selc_pkg::ENTRY_W-1:0] s1_row_ff;
   logic [selc_pkg::ENTRY_W-1:0] s1_col_ff;
   logic                         s1_fire;
   logic                         s1_mark_wr;
   logic                         out_ready;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [selc_pkg::ENTRY_W-1:0] new_row_in, new_row_ff;
   logic [selc_pkg::ENTRY_W-1:0] new_col_in, new_col_ff;
   logic [selc_pkg::DIM_W-1:0]   new_num_rows_in, new_num_rows_ff;
   logic [selc_pkg::DIM_W-1:0]   new_num_cols_in, new_num_cols_ff;
   logic                         has_empty_in, has_empty_ff;
   logic                         oor_in, oor_ff;

   selc_pkg::row_req_type        seq_row_req, top_row_req, row_req;
   selc_pkg::col_req_type        seq_col_req, top_col_req, col_req;
   selc_pkg::seq_stat_type       seq_stat;
   logic [selc_pkg::WORD_W-1:0]  row_rd;
   logic [selc_pkg::WORD_W-1:0]  col_rd;

   // A zero dimension acts as one, and one above the memory depth as the depth.
   function automatic logic [selc_pkg::DIM_W-1:0] clamp_dim(
      input logic [selc_pkg::DIM_W-1:0] value,
      input int                         limit
   );
      logic [selc_pkg::DIM_W-1:0] result;
      if (value == '0) begin
         result = {{(selc_pkg::DIM_W-1){1'b0}}, 1'b1};
      end else if (int'(value) > limit) begin
         result = selc_pkg::DIM_W'(limit);
      end else begin
         result = value;
      end
      return result;
   endfunction

   // Configuration registers; writes beyond the list are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= selc_pkg::DIM_RESET;
         num_cols_ff <= selc_pkg::DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            selc_pkg::CSR_NUM_ROWS: num_rows_ff <= csr_data;
            selc_pkg::CSR_NUM_COLS: num_cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign dim_rows = clamp_dim(num_rows_ff, selc_pkg::MAX_ROWS);
   assign dim_cols = clamp_dim(num_cols_ff, selc_pkg::MAX_COLS);

   // Request acceptance: no request while walking or while the read stage is blocked.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_ready;
   assign req_stall = seq_stat.busy || (s1_valid_ff && !out_ready);
   assign req_fire  = req_valid && !req_stall;
   assign req_act   = selc_pkg::action_type'(req_action);
   assign req_oor   = ({1'b0, req_entry_row} >= dim_rows) ||
                      ({1'b0, req_entry_col} >= dim_cols);

   // Read stage: marks and remaps read both maps; a finished build takes the slot.
   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_fire;
      if (req_fire && ((req_act == selc_pkg::ACT_MARK) || (req_act == selc_pkg::ACT_REMAP))) begin
         s1_valid_in = 1'b1;
      end else if (seq_stat.done) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= req_act;
         s1_oor_ff    <= req_oor;
         s1_row_ff    <= req_entry_row;
         s1_col_ff    <= req_entry_col;
      end else if (seq_stat.done) begin
         s1_action_ff <= selc_pkg::ACT_BUILD;
         s1_oor_ff    <= 1'b0;
      end
   end

   // Memory access of the request path: read at acceptance, mark write-back on release.
   assign s1_mark_wr = s1_fire && (s1_action_ff == selc_pkg::ACT_MARK) && !s1_oor_ff;

   always_comb begin
      top_row_req         = '0;
      top_col_req         = '0;
      top_row_req.rd_en   = req_fire;
      top_row_req.rd_addr = selc_pkg::ROW_AW'(req_entry_row);
      top_col_req.rd_en   = req_fire;
      top_col_req.rd_addr = selc_pkg::COL_AW'(req_entry_col);
      top_row_req.wr_en   = s1_mark_wr;
      top_row_req.wr_addr = selc_pkg::ROW_AW'(s1_row_ff);
      top_row_req.wr_data = {1'b1, row_rd[selc_pkg::DIM_W-1:0]};
      top_col_req.wr_en   = s1_mark_wr;
      top_col_req.wr_addr = selc_pkg::COL_AW'(s1_col_ff);
      top_col_req.wr_data = {1'b1, col_rd[selc_pkg::DIM_W-1:0]};
   end

   assign row_req = seq_stat.busy ? seq_row_req : top_row_req;
   assign col_req = seq_stat.busy ? seq_col_req : top_col_req;

   selc_maps u_maps (
      .clock   (clock),
      .reset   (reset),
      .row_req (row_req),
      .col_req (col_req),
      .row_rd  (row_rd),
      .col_rd  (col_rd)
   );

   selc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start_clear (req_fire && (req_act == selc_pkg::ACT_CLEAR)),
      .start_build (req_fire && (req_act == selc_pkg::ACT_BUILD)),
      .dim_rows    (dim_rows),
      .dim_cols    (dim_cols),
      .row_rd      (row_rd),
      .col_rd      (col_rd),
      .row_req     (seq_row_req),
      .col_req     (seq_col_req),
      .stat        (seq_stat)
   );

   // Result fields of the item in the read stage.
   always_comb begin
      new_row_in      = '0;
      new_col_in      = '0;
      new_num_rows_in = '0;
      new_num_cols_in = '0;
      has_empty_in    = 1'b0;
      oor_in          = 1'b0;
      unique case (s1_action_ff)
         selc_pkg::ACT_MARK: begin
            oor_in = s1_oor_ff;
         end
         selc_pkg::ACT_REMAP: begin
            oor_in = s1_oor_ff;
            if (!s1_oor_ff) begin
               new_row_in = selc_pkg::ENTRY_W'({1'b0, s1_row_ff} -
                                               row_rd[selc_pkg::DIM_W-1:0]);
               new_col_in = selc_pkg::ENTRY_W'({1'b0, s1_col_ff} -
                                               col_rd[selc_pkg::DIM_W-1:0]);
            end
         end
         selc_pkg::ACT_BUILD: begin
            new_num_rows_in = dim_rows - seq_stat.empty_rows;
            new_num_cols_in = dim_cols - seq_stat.empty_cols;
            has_empty_in    = (seq_stat.empty_rows != '0) || (seq_stat.empty_cols != '0);
         end
         selc_pkg::ACT_CLEAR: begin
            oor_in = 1'b0;
         end
         default: begin
            oor_in = 1'b0;
         end
      endcase
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         new_row_ff      <= new_row_in;
         new_col_ff      <= new_col_in;
         new_num_rows_ff <= new_num_rows_in;
         new_num_cols_ff <= new_num_cols_in;
         has_empty_ff    <= has_empty_in;
         oor_ff          <= oor_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_row      = new_row_ff;
   assign rsp_new_col      = new_col_ff;
   assign rsp_new_num_rows = new_num_rows_ff;
   assign rsp_new_num_cols = new_num_cols_ff;
   assign rsp_has_empty    = has_empty_ff;
   assign rsp_out_of_range = oor_ff;

   // A finished build always lands in the read stage.
   a_build_lands: assert property (@(posedge clock) disable iff (reset)
      seq_stat.done |=> (s1_valid_ff && (s1_action_ff == selc_pkg::ACT_BUILD)))
      else $error("build result did not enter the read stage");

   // Mark write-backs never collide with a memory walk.
   a_no_walk_overlap: assert property (@(posedge clock) disable iff (reset)
      !(s1_mark_wr && seq_stat.busy))
      else $error("mark write-back during a memory walk");

   // A new response only follows a release of the read stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire))
      else $error("response appeared without a released request");

endmodule
